[sv/priority_task_table_assert.svh]
// assertion macros for the task table
// used by the top level only
`ifndef PRIORITY_TASK_TABLE_ASSERT_SVH
`define PRIORITY_TASK_TABLE_ASSERT_SVH
// implication checked on every clock, quiet in reset
`define PTT_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
// next-cycle implication
`define PTT_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

[sv/ptt_pkg.sv]
// shared types and constants of the task table
// no dependencies
package ptt_pkg;
    localparam int SLOTS = 32;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_SETCUR = 3'd2;
    localparam logic [2:0] OP_SLEEP  = 3'd3;
    localparam logic [2:0] OP_WAKE   = 3'd4;
    localparam logic [2:0] OP_EXIT   = 3'd5;
    localparam logic [2:0] OP_SELECT = 3'd6;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    localparam logic [2:0] RS_OK       = 3'd0;
    localparam logic [2:0] RS_FULL     = 3'd1;
    localparam logic [2:0] RS_NOTFOUND = 3'd2;
    localparam logic [2:0] RS_NOCUR    = 3'd3;
    localparam logic [2:0] RS_NONE     = 3'd4;

    // one slot record as it travels around the ring
    typedef struct packed {
        logic [2:0]  state;
        logic [30:0] id;
        logic [7:0]  prio;
        logic [63:0] deadline;
        logic [31:0] exit_code;
    } slot_t;

    // command broadcast to every cell during a pass
    typedef struct packed {
        logic        rotate;
        logic        wake;
        logic [63:0] now_time;
    } cell_ctl_t;
endpackage

[sv/ptt_cell.sv]
// one slot cell of the task ring; hands its record to the next cell on rotate
// depends on ptt_pkg
module ptt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ptt_pkg::cell_ctl_t ctl,
    input  ptt_pkg::slot_t     prev_slot,
    output ptt_pkg::slot_t     slot
);
    logic [2:0]     state_reg;
    logic [2:0]     state_next;
    logic [30:0]    id_reg;
    ptt_pkg::slot_t pay_reg;

    always_comb
    begin
        state_next = state_reg;
        if (ctl.rotate)
        begin
            state_next = prev_slot.state;
            // wake folds into the record as it enters this cell
            if (ctl.wake && prev_slot.state == ptt_pkg::ST_SLEEPING
                && ctl.now_time >= prev_slot.deadline)
                state_next = ptt_pkg::ST_READY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptt_pkg::ST_UNUSED;
            id_reg    <= '0;
        end
        else if (ctl.rotate)
        begin
            state_reg <= state_next;
            id_reg    <= prev_slot.id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rotate)
            pay_reg <= prev_slot;
    end

    always_comb
    begin
        slot       = pay_reg;
        slot.state = state_reg;
        slot.id    = id_reg;
    end
endmodule

[sv/ptt_ring.sv]
// ring of slot cells; cell 0 is the head, it receives the modified tail record
// depends on ptt_pkg, ptt_cell
module ptt_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  ptt_pkg::cell_ctl_t ctl,
    input  ptt_pkg::slot_t     tail_in,
    output ptt_pkg::slot_t     tail_out
);
    ptt_pkg::slot_t chain [ptt_pkg::SLOTS];

    for (genvar g = 0; g < ptt_pkg::SLOTS; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            ptt_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl),
                             .prev_slot(tail_in), .slot(chain[g]));
        end
        else
        begin : g_body
            ptt_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl),
                             .prev_slot(chain[g-1]), .slot(chain[g]));
        end
    end

    assign tail_out = chain[ptt_pkg::SLOTS-1];
endmodule

[sv/priority_task_table.sv]
// priority task table: each command first rotates the record ring once through every slot
// in the scan state, then registers the result in the done state, then raises the strobe.
// a new command is accepted only while idle; busy is high from accept until the strobe.
// the result strobe is high for one cycle and cannot be held off by the receiver.
// asynchronous active-low reset clears all slots to unused, id counter to one,
// and the current task to none.
`include "priority_task_table_assert.svh"
module priority_task_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [7:0]  priority_req,
    input  logic [30:0] task_id,
    input  logic [31:0] ticks,
    input  logic [63:0] now_time,
    input  logic signed [31:0] exit_code,
    output logic        done,
    output logic [2:0]  status,
    output logic [30:0] result_id,
    output logic [4:0]  result_slot,
    output logic [7:0]  result_priority,
    output logic [2:0]  result_state
);
    localparam int IW = ptt_pkg::IDX_W;
    localparam int CW = ptt_pkg::CNT_W;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]     fsm_reg, fsm_next;
    logic [CW-1:0]  cnt_reg;
    logic [2:0]     op_reg;
    logic [7:0]     prio_reg;
    logic [30:0]    tid_reg;
    logic [63:0]    now_reg;
    logic [63:0]    dl_reg;
    logic [31:0]    code_reg;
    logic [30:0]    idc_reg;
    logic [IW-1:0]  cur_reg;
    logic           cur_vld_reg;
    // hit: slot found during pass; hit_idx its index; best_prio tracks best
    logic           hit_reg;
    logic [IW-1:0]  hit_idx_reg;
    logic [7:0]     best_prio_reg;
    ptt_pkg::slot_t hit_rec_reg;
    logic           done_reg;
    logic [2:0]     st_reg;
    logic [30:0]    rid_reg;
    logic [4:0]     rslot_reg;
    logic [7:0]     rprio_reg;
    logic [2:0]     rstate_reg;

    ptt_pkg::cell_ctl_t ctl;
    ptt_pkg::slot_t     tail, head_in;
    logic [IW-1:0]      idx;
    logic               used, match, take;

    assign idx  = cnt_reg[IW-1:0];
    assign ctl.rotate   = (fsm_reg == S_SCAN);
    assign ctl.wake     = (op_reg == ptt_pkg::OP_WAKE);
    assign ctl.now_time = now_reg;
    assign used  = tail.state != ptt_pkg::ST_UNUSED;

    ptt_ring u_ring (.clk(clk), .rst_n(rst_n), .ctl(ctl),
                     .tail_in(head_in), .tail_out(tail));

    // per-slot decision as the tail record passes by, slot index idx
    always_comb
    begin
        head_in = tail;
        match   = 1'b0;
        take    = 1'b0;
        case (op_reg)
            ptt_pkg::OP_CREATE:
            begin
                match = !used && !hit_reg;
                if (match)
                begin
                    head_in.state    = ptt_pkg::ST_READY;
                    head_in.id       = idc_reg;
                    head_in.prio     = prio_reg;
                    head_in.deadline = '0;
                end
            end
            ptt_pkg::OP_LOOKUP, ptt_pkg::OP_SETCUR:
                match = used && tail.id == tid_reg && !hit_reg;
            ptt_pkg::OP_SLEEP:
            begin
                match = cur_vld_reg && idx == cur_reg;
                if (match)
                begin
                    head_in.state    = ptt_pkg::ST_SLEEPING;
                    head_in.deadline = dl_reg;
                end
            end
            ptt_pkg::OP_EXIT:
            begin
                match = cur_vld_reg && idx == cur_reg;
                if (match)
                begin
                    head_in.state     = ptt_pkg::ST_ZOMBIE;
                    head_in.exit_code = code_reg;
                end
            end
            ptt_pkg::OP_SELECT:
                match = tail.state == ptt_pkg::ST_READY
                        && (!hit_reg || tail.prio > best_prio_reg);
            default: ;
        endcase
        take = match;
    end

    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            S_IDLE:  if (start) fsm_next = S_SCAN;
            S_SCAN:  if (cnt_reg == CW'(ptt_pkg::SLOTS - 1)) fsm_next = S_DONE;
            S_DONE:  fsm_next = S_IDLE;
            default: fsm_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg     <= S_IDLE;
            cnt_reg     <= '0;
            idc_reg     <= 31'd1;
            cur_vld_reg <= 1'b0;
            cur_reg     <= '0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            fsm_reg  <= fsm_next;
            done_reg <= 1'b0;
            case (fsm_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    hit_reg <= 1'b0;
                end
                S_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (take)
                        hit_reg <= 1'b1;
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    if (op_reg == ptt_pkg::OP_CREATE && hit_reg)
                        idc_reg <= idc_reg + 1'b1;
                    if (op_reg == ptt_pkg::OP_SETCUR)
                    begin
                        cur_vld_reg <= hit_reg;
                        cur_reg     <= hit_idx_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fsm_reg == S_IDLE && start)
        begin
            op_reg   <= opcode;
            prio_reg <= priority_req;
            tid_reg  <= task_id;
            now_reg  <= now_time;
            dl_reg   <= now_time + {32'd0, ticks};
            code_reg <= exit_code;
        end
        if (fsm_reg == S_SCAN && take)
        begin
            hit_idx_reg   <= idx;
            best_prio_reg <= tail.prio;
            hit_rec_reg   <= head_in;
        end
        if (fsm_reg == S_DONE)
        begin
            st_reg     <= ptt_pkg::RS_OK;
            rid_reg    <= '0;
            rslot_reg  <= '0;
            rprio_reg  <= '0;
            rstate_reg <= '0;
            // wake and the unused opcode never hit
            if (hit_reg)
            begin
                rid_reg    <= hit_rec_reg.id;
                rslot_reg  <= 5'(hit_idx_reg);
                rprio_reg  <= hit_rec_reg.prio;
                rstate_reg <= hit_rec_reg.state;
            end
            else
            begin
                case (op_reg)
                    ptt_pkg::OP_CREATE: st_reg <= ptt_pkg::RS_FULL;
                    ptt_pkg::OP_LOOKUP, ptt_pkg::OP_SETCUR:
                        st_reg <= ptt_pkg::RS_NOTFOUND;
                    ptt_pkg::OP_SLEEP, ptt_pkg::OP_EXIT:
                        st_reg <= ptt_pkg::RS_NOCUR;
                    ptt_pkg::OP_SELECT: st_reg <= ptt_pkg::RS_NONE;
                    default: st_reg <= ptt_pkg::RS_OK;
                endcase
            end
        end
    end

    assign busy            = (fsm_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = st_reg;
    assign result_id       = rid_reg;
    assign result_slot     = rslot_reg;
    assign result_priority = rprio_reg;
    assign result_state    = rstate_reg;

    `PTT_ASSERT_IMP(a_done_idle, done_reg, fsm_reg == S_IDLE)
    `PTT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `PTT_ASSERT_IMP(a_fail_zero, done_reg && st_reg != ptt_pkg::RS_OK, rid_reg == '0)
endmodule

[tb/sv/tb_priority_task_table.sv]
// self-checking testbench for priority_task_table: directed and random commands
// with a built-in predictor of the slot table; depends on ptt_pkg and the block
module tb_priority_task_table;
    localparam logic [2:0] OP_NOP = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 60;
    localparam logic [30:0] ID_MASK = 31'h7fffffff;

    typedef struct {
        logic [2:0]  status;
        logic [30:0] id;
        logic [4:0]  slot;
        logic [7:0]  prio;
        logic [2:0]  state;
    } task_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  opcode;
    logic [7:0]  priority_req;
    logic [30:0] task_id;
    logic [31:0] ticks;
    logic [63:0] now_time;
    logic signed [31:0] exit_code;
    logic        done;
    logic [2:0]  status;
    logic [30:0] result_id;
    logic [4:0]  result_slot;
    logic [7:0]  result_priority;
    logic [2:0]  result_state;

    // shadow copy of the task table
    logic [2:0]  tbl_state [ptt_pkg::SLOTS];
    logic [30:0] tbl_id [ptt_pkg::SLOTS];
    logic [7:0]  tbl_prio [ptt_pkg::SLOTS];
    logic [63:0] tbl_deadline [ptt_pkg::SLOTS];
    logic [31:0] tbl_exit [ptt_pkg::SLOTS];
    logic [30:0] next_id;
    int          cur_slot;
    bit          cur_valid;

    task_result_t pending_results[$];
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          idle_enable;
    logic [63:0] sim_now;

    priority_task_table DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .priority_req(priority_req), .task_id(task_id),
        .ticks(ticks), .now_time(now_time), .exit_code(exit_code),
        .done(done), .status(status), .result_id(result_id),
        .result_slot(result_slot), .result_priority(result_priority),
        .result_state(result_state)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < MAX_REPORTS)
            $display("ERROR %0t %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic task_result_t table_result(logic [2:0] st, int idx);
        task_result_t r;
        r = '{st, 31'd0, 5'd0, 8'd0, ptt_pkg::ST_UNUSED};
        if (st == ptt_pkg::RS_OK && idx < ptt_pkg::SLOTS)
        begin
            r.id = tbl_id[idx];
            r.slot = idx[4:0];
            r.prio = tbl_prio[idx];
            r.state = tbl_state[idx];
        end
        return r;
    endfunction

    function automatic int find_task(logic [30:0] id);
        for (int i = 0; i < ptt_pkg::SLOTS; i++)
            if (tbl_state[i] != ptt_pkg::ST_UNUSED && tbl_id[i] == id)
                return i;
        return ptt_pkg::SLOTS;
    endfunction

    // update the shadow table and queue the result the block must give
    task automatic predict_command(logic [2:0] op, logic [7:0] prio, logic [30:0] id,
                                   logic [31:0] tk, logic [63:0] now, logic [31:0] code);
        int idx;
        task_result_t r;
        idx = ptt_pkg::SLOTS;
        case (op)
            ptt_pkg::OP_CREATE:
            begin
                for (int i = ptt_pkg::SLOTS - 1; i >= 0; i--)
                    if (tbl_state[i] == ptt_pkg::ST_UNUSED)
                        idx = i;
                if (idx >= ptt_pkg::SLOTS)
                    r = table_result(ptt_pkg::RS_FULL, 0);
                else
                begin
                    tbl_id[idx] = next_id;
                    next_id = (next_id + 31'd1) & ID_MASK;
                    tbl_state[idx] = ptt_pkg::ST_READY;
                    tbl_prio[idx] = prio;
                    tbl_deadline[idx] = 64'd0;
                    r = table_result(ptt_pkg::RS_OK, idx);
                end
            end
            ptt_pkg::OP_LOOKUP:
            begin
                idx = find_task(id);
                r = table_result(idx < ptt_pkg::SLOTS ? ptt_pkg::RS_OK
                                                      : ptt_pkg::RS_NOTFOUND, idx);
            end
            ptt_pkg::OP_SETCUR:
            begin
                idx = find_task(id);
                cur_valid = (idx < ptt_pkg::SLOTS);
                if (cur_valid)
                    cur_slot = idx;
                r = table_result(cur_valid ? ptt_pkg::RS_OK : ptt_pkg::RS_NOTFOUND, idx);
            end
            ptt_pkg::OP_SLEEP, ptt_pkg::OP_EXIT:
            begin
                if (!cur_valid)
                    r = table_result(ptt_pkg::RS_NOCUR, 0);
                else
                begin
                    if (op == ptt_pkg::OP_SLEEP)
                    begin
                        tbl_state[cur_slot] = ptt_pkg::ST_SLEEPING;
                        tbl_deadline[cur_slot] = now + {32'd0, tk};
                    end
                    else
                    begin
                        tbl_state[cur_slot] = ptt_pkg::ST_ZOMBIE;
                        tbl_exit[cur_slot] = code;
                    end
                    r = table_result(ptt_pkg::RS_OK, cur_slot);
                end
            end
            ptt_pkg::OP_WAKE:
            begin
                for (int i = 0; i < ptt_pkg::SLOTS; i++)
                    if (tbl_state[i] == ptt_pkg::ST_SLEEPING && now >= tbl_deadline[i])
                        tbl_state[i] = ptt_pkg::ST_READY;
                r = table_result(ptt_pkg::RS_OK, ptt_pkg::SLOTS);
            end
            ptt_pkg::OP_SELECT:
            begin
                for (int i = 0; i < ptt_pkg::SLOTS; i++)
                    if (tbl_state[i] == ptt_pkg::ST_READY
                        && (idx >= ptt_pkg::SLOTS || tbl_prio[i] > tbl_prio[idx]))
                        idx = i;
                r = table_result(idx < ptt_pkg::SLOTS ? ptt_pkg::RS_OK
                                                      : ptt_pkg::RS_NONE, idx);
            end
            default:
                r = table_result(ptt_pkg::RS_OK, ptt_pkg::SLOTS);
        endcase
        pending_results.push_back(r);
    endtask

    task automatic send_command(logic [2:0] op, logic [7:0] prio, logic [30:0] id,
                                logic [31:0] tk, logic [63:0] now, logic [31:0] code);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        opcode <= op;
        priority_req <= prio;
        task_id <= id;
        ticks <= tk;
        now_time <= now;
        exit_code <= code;
        do @(posedge clk); while (busy);
        predict_command(op, prio, id, tk, now, code);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [30:0] known_id();
        if (next_id > 31'd1 && $urandom_range(0, 7) != 0)
            return 31'($urandom_range(1, next_id - 1));
        return 31'($urandom) & ID_MASK;
    endfunction

    task automatic test_empty_table();
        send_command(ptt_pkg::OP_SELECT, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_SLEEP, 8'd0, 31'd0, 32'd5, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_EXIT, 8'd0, 31'd0, 32'd0, 64'd0, 32'h7fffffff);
        send_command(ptt_pkg::OP_LOOKUP, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_SETCUR, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_WAKE, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(OP_NOP, 8'hff, ID_MASK, 32'hffffffff, '1, 32'hffffffff);
    endtask

    task automatic test_current_task();
        send_command(ptt_pkg::OP_CREATE, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_CREATE, 8'd255, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_CREATE, 8'd255, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_CREATE, 8'd128, 31'd0, 32'd0, 64'd0, 32'd0);
        // tie on priority goes to the lower slot
        send_command(ptt_pkg::OP_SELECT, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_SETCUR, 8'd0, 31'd2, 32'd0, 64'd0, 32'd0);
        // deadline wraps past the top of the timer
        send_command(ptt_pkg::OP_SLEEP, 8'd0, 31'd0, 32'hffffffff, '1, 32'd0);
        send_command(ptt_pkg::OP_WAKE, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_SELECT, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_WAKE, 8'd0, 31'd0, 32'd0, '1, 32'd0);
        send_command(ptt_pkg::OP_EXIT, 8'd0, 31'd0, 32'd0, 64'd0, 32'h80000000);
        send_command(ptt_pkg::OP_LOOKUP, 8'd0, 31'd2, 32'd0, 64'd0, 32'd0);
        // a zombie can still be put to sleep
        send_command(ptt_pkg::OP_SLEEP, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_EXIT, 8'd0, 31'd0, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_SETCUR, 8'd0, ID_MASK, 32'd0, 64'd0, 32'd0);
        send_command(ptt_pkg::OP_SLEEP, 8'd0, 31'd0, 32'd1, 64'd0, 32'd0);
    endtask

    task automatic test_table_full();
        repeat (ptt_pkg::SLOTS + 2)
            send_command(ptt_pkg::OP_CREATE, 8'($urandom), 31'($urandom), 32'd0, 64'd0,
                         32'd0);
        wait_drained();
    endtask

    task automatic test_random_mix(int count);
        logic [2:0]  op;
        logic [31:0] tk;
        logic [63:0] now;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            sim_now += 64'($urandom_range(0, 40));
            tk = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 300));
            now = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom} : sim_now;
            pick = $urandom_range(0, 99);
            if (pick < 6)       op = ptt_pkg::OP_CREATE;
            else if (pick < 20) op = ptt_pkg::OP_LOOKUP;
            else if (pick < 40) op = ptt_pkg::OP_SETCUR;
            else if (pick < 55) op = ptt_pkg::OP_SLEEP;
            else if (pick < 72) op = ptt_pkg::OP_WAKE;
            else if (pick < 80) op = ptt_pkg::OP_EXIT;
            else if (pick < 97) op = ptt_pkg::OP_SELECT;
            else                op = OP_NOP;
            send_command(op, 8'($urandom), known_id(), tk, now, $urandom);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        task_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 64'(status), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 64'(status), 64'(want.status));
                if (result_id !== want.id)
                    report_mismatch("result_id", 64'(result_id), 64'(want.id));
                if (result_slot !== want.slot)
                    report_mismatch("result_slot", 64'(result_slot), 64'(want.slot));
                if (result_priority !== want.prio)
                    report_mismatch("result_priority", 64'(result_priority), 64'(want.prio));
                if (result_state !== want.state)
                    report_mismatch("result_state", 64'(result_state), 64'(want.state));
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("priority_task_table: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_NOP;
        priority_req = '0;
        task_id = '0;
        ticks = '0;
        now_time = '0;
        exit_code = '0;
        idle_enable = 1'b1;
        sim_now = 64'd1000;
        next_id = 31'd1;
        cur_slot = 0;
        cur_valid = 1'b0;
        for (int i = 0; i < ptt_pkg::SLOTS; i++)
        begin
            tbl_state[i] = ptt_pkg::ST_UNUSED;
            tbl_id[i] = '0;
            tbl_prio[i] = '0;
            tbl_deadline[i] = '0;
            tbl_exit[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_current_task();
        test_table_full();
        test_random_mix(800);
        wait_drained();
        test_random_mix(750);
        idle_enable = 1'b0;
        test_random_mix(150);

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("priority_task_table: match");
        else
            $display("priority_task_table: mismatch");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/ptt_pkg.sv
sv/ptt_cell.sv
sv/ptt_ring.sv
sv/priority_task_table.sv
tb/sv/tb_priority_task_table.sv
